@@ sv/pci_pkg.sv @@
// ----------------------------------------------------------------------------
// pci_pkg
// Shared types and constants of the PID controller with integral clamp.
// ----------------------------------------------------------------------------
package pci_pkg;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int ERR_W    = 17;
   localparam int SUM_W    = 32;
   localparam int DRIVE_W  = 16;
   localparam int DUTY_W   = 16;
   localparam int BAND_W   = 17;
   localparam int PROD_W   = 48;
   localparam int TOT_W    = 50;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT      = 3'd0,
      CSR_GAIN_P        = 3'd1,
      CSR_GAIN_I        = 3'd2,
      CSR_GAIN_D        = 3'd3,
      CSR_ERROR_BAND    = 3'd4,
      CSR_INTEGRAL_DUTY = 3'd5,
      CSR_FULL_DUTY     = 3'd6
   } csr_index_type;

   // register reset values
   localparam logic [BAND_W-1:0] ERROR_BAND_RST = 17'd131071;
   localparam logic [DUTY_W-1:0] FULL_DUTY_RST  = 16'd1000;

   // item actions
   localparam logic ACTION_PROCESS = 1'b0;
   localparam logic ACTION_CLEAR   = 1'b1;

   // multiplier operand pair
   typedef enum logic [1:0] {
      MUL_SEL_P,
      MUL_SEL_I,
      MUL_SEL_D
   } mul_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        clear;
      logic        load;
      logic        div_step;
      logic        lim_load;
      logic        clamp;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_clr;
      logic        acc_add;
      logic        out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

@@ sv/pci_req_if.sv @@
// ----------------------------------------------------------------------------
// pci_req_if
// Input item channel: action and measured sample.
// ----------------------------------------------------------------------------
interface pci_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   action;
   logic signed [pci_pkg::SAMPLE_W-1:0]    current_sample;

   modport source (output valid, output action, output current_sample, input ready);
   modport sink   (input valid, input action, input current_sample, output ready);
endinterface

@@ sv/pci_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pci_rsp_if
// Result item channel: drive value.
// ----------------------------------------------------------------------------
interface pci_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pci_pkg::DRIVE_W-1:0]    drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

@@ sv/pid_controller_integral_clamp.sv @@
// ----------------------------------------------------------------------------
// pid_controller_integral_clamp
// Positional PID controller with anti-windup clamp on the integral sum.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one item per handshake: action 0 processes current_sample
//   (signed Q12.4), action 1 clears both errors and the integral sum and
//   gives no result. rsp_bus returns one drive value per processed item.
//   Gains and limits are written through csr_wr_en / csr_index / csr_wdata
//   while the block is idle; unknown indexes are ignored.
// Sequence:
//   a processed item runs the restoring divider for the integral limit
//   (one quotient bit a cycle, PRODUCT_SHIFT + 17 bits), then three passes
//   through one shared 16x32 multiplier; the block takes no next item until
//   its drive is loaded into the output register, and the drive shows on
//   rsp_bus in the same cycle that the block is ready again. After a clear
//   item the block can take the next item in the following cycle.
// Reset and stalls:
//   reset zeroes the errors and the sum and loads the register defaults.
//   The drive sits in an output register; while the receiver stalls, a next
//   item is still taken and computed, and waits only for the slot to free.
// ----------------------------------------------------------------------------
module pid_controller_integral_clamp #(
   parameter int PRODUCT_SHIFT = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   pci_req_if.sink                           req_bus,
   pci_rsp_if.source                         rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [pci_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pci_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   pci_pkg::cmd_type    cmd;
   pci_pkg::status_type status;

   // sequencer
   pci_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .req_ready  (req_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .status_i   (status),
      .cmd_o      (cmd)
   );

   // arithmetic and state
   pci_dp #(
      .PRODUCT_SHIFT (PRODUCT_SHIFT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .current_sample (req_bus.current_sample),
      .cmd_i          (cmd),
      .status_o       (status),
      .drive          (rsp_bus.drive)
   );

endmodule

@@ sv/pci_ctrl.sv @@
// ----------------------------------------------------------------------------
// pci_ctrl
// Sequencer: accepts an item, steps the divider, the clamp and the shared
// multiplier, then hands the drive to the output register.
// ----------------------------------------------------------------------------
module pci_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pci_pkg::status_type  status_i,
   output pci_pkg::cmd_type     cmd_o
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LIMIT,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // handshake
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // commands and next state
   always_comb begin
      cmd_o        = '0;
      cmd_o.mul_sel = pci_pkg::MUL_SEL_P;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == pci_pkg::ACTION_CLEAR) begin
                  cmd_o.clear = 1'b1;
               end else begin
                  cmd_o.load = 1'b1;
                  state_in   = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd_o.div_step = 1'b1;
            if (status_i.div_last) begin
               state_in = ST_LIMIT;
            end
         end
         ST_LIMIT: begin
            cmd_o.lim_load = 1'b1;
            state_in       = ST_MUL_P;
         end
         ST_MUL_P: begin
            cmd_o.clamp   = 1'b1;
            cmd_o.mul_en  = 1'b1;
            cmd_o.mul_sel = pci_pkg::MUL_SEL_P;
            cmd_o.acc_clr = 1'b1;
            state_in      = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd_o.mul_en  = 1'b1;
            cmd_o.mul_sel = pci_pkg::MUL_SEL_I;
            cmd_o.acc_add = 1'b1;
            state_in      = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd_o.mul_en  = 1'b1;
            cmd_o.mul_sel = pci_pkg::MUL_SEL_D;
            cmd_o.acc_add = 1'b1;
            state_in      = ST_ACC;
         end
         ST_ACC: begin
            cmd_o.acc_add = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for a free output slot
            if (!rsp_valid_ff || rsp_ready) begin
               cmd_o.out_load = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   a_load_only_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd_o.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten while a result waits");

   a_clear_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == pci_pkg::ACTION_CLEAR) |=> (state_ff == ST_IDLE))
      else $error("clear item started a computation");

   a_process_starts_divide: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == pci_pkg::ACTION_PROCESS) |=> (state_ff == ST_DIVIDE))
      else $error("process item did not start the divider");

   a_divide_ends_in_limit: assert property (@(posedge clock) disable iff (reset)
      (cmd_o.div_step && status_i.div_last) |=> (state_ff == ST_LIMIT))
      else $error("divider finish not followed by limit load");

endmodule

@@ sv/pci_dp.sv @@
// ----------------------------------------------------------------------------
// pci_dp
// Datapath: configuration registers, error and integral state, bit-serial
// limit divider, shared 16x32 multiplier with accumulator, output register.
// ----------------------------------------------------------------------------
module pci_dp #(
   parameter int PRODUCT_SHIFT = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [pci_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pci_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic signed [pci_pkg::SAMPLE_W-1:0]   current_sample,
   input  pci_pkg::cmd_type                      cmd_i,
   output pci_pkg::status_type                   status_o,
   output logic [pci_pkg::DRIVE_W-1:0]           drive
);

   localparam int NUM_W = pci_pkg::DUTY_W + 1 + PRODUCT_SHIFT;
   localparam int LIM_W = NUM_W + 1;
   localparam int CW    = ((LIM_W > pci_pkg::SUM_W + 1) ? LIM_W : pci_pkg::SUM_W + 1) + 1;
   localparam int CNT_W = $clog2(NUM_W);
   localparam int GW    = pci_pkg::GAIN_W;
   localparam int EW    = pci_pkg::ERR_W;
   localparam int SW    = pci_pkg::SUM_W;
   localparam int TW    = pci_pkg::TOT_W;

   localparam logic signed [SW:0] SUM_MAX = 33'sd2147483647;
   localparam logic signed [SW:0] SUM_MIN = -33'sd2147483648;

   // configuration registers
   logic signed [GW-1:0]                 setpoint_ff, gain_p_ff, gain_i_ff, gain_d_ff;
   logic [pci_pkg::BAND_W-1:0]           error_band_ff;
   logic [pci_pkg::DUTY_W-1:0]           integral_duty_ff, full_duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff      <= '0;
         gain_p_ff        <= '0;
         gain_i_ff        <= '0;
         gain_d_ff        <= '0;
         error_band_ff    <= pci_pkg::ERROR_BAND_RST;
         integral_duty_ff <= '0;
         full_duty_ff     <= pci_pkg::FULL_DUTY_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            pci_pkg::CSR_SETPOINT:      setpoint_ff      <= csr_wdata[GW-1:0];
            pci_pkg::CSR_GAIN_P:        gain_p_ff        <= csr_wdata[GW-1:0];
            pci_pkg::CSR_GAIN_I:        gain_i_ff        <= csr_wdata[GW-1:0];
            pci_pkg::CSR_GAIN_D:        gain_d_ff        <= csr_wdata[GW-1:0];
            pci_pkg::CSR_ERROR_BAND:    error_band_ff    <= csr_wdata;
            pci_pkg::CSR_INTEGRAL_DUTY: integral_duty_ff <= csr_wdata[pci_pkg::DUTY_W-1:0];
            pci_pkg::CSR_FULL_DUTY:     full_duty_ff     <= csr_wdata[pci_pkg::DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // new error and saturated running sum
   logic signed [EW-1:0] error_now_ff, error_before_ff, err_new;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [SW:0]   sum_wide;
   logic [EW-1:0]        err_mag;
   logic signed [CW-1:0] lim_x, nlim_x, sum_x, clamp_x;
   logic signed [LIM_W-1:0] lim_ff, lim_in;

   assign err_new  = EW'(setpoint_ff) - EW'(current_sample);
   assign err_mag  = err_new[EW-1] ? EW'(-err_new) : err_new;
   assign sum_wide = (SW+1)'(sum_ff) + (SW+1)'(err_new);

   // clamp against the integral limit
   assign lim_x  = CW'(lim_ff);
   assign nlim_x = -lim_x;
   assign sum_x  = CW'(sum_ff);

   always_comb begin
      if (sum_x > lim_x) begin
         clamp_x = lim_x;
      end else if (sum_x < nlim_x) begin
         clamp_x = nlim_x;
      end else begin
         clamp_x = sum_x;
      end
   end

   always_comb begin
      sum_in = sum_ff;
      if (cmd_i.load) begin
         if (err_mag > error_band_ff) begin
            sum_in = '0;
         end else if (sum_wide > SUM_MAX) begin
            sum_in = SUM_MAX[SW-1:0];
         end else if (sum_wide < SUM_MIN) begin
            sum_in = SUM_MIN[SW-1:0];
         end else begin
            sum_in = sum_wide[SW-1:0];
         end
      end else if (cmd_i.clamp) begin
         if (clamp_x > CW'(SUM_MAX)) begin
            sum_in = SUM_MAX[SW-1:0];
         end else if (clamp_x < CW'(SUM_MIN)) begin
            sum_in = SUM_MIN[SW-1:0];
         end else begin
            sum_in = clamp_x[SW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_now_ff    <= '0;
         error_before_ff <= '0;
         sum_ff          <= '0;
      end else if (cmd_i.clear) begin
         error_now_ff    <= '0;
         error_before_ff <= '0;
         sum_ff          <= '0;
      end else begin
         if (cmd_i.load) begin
            error_before_ff <= error_now_ff;
            error_now_ff    <= err_new;
         end
         sum_ff <= sum_in;
      end
   end

   // restoring divider, one quotient bit per step
   logic [GW-1:0]     rem_ff, rem_in, dvs_ff;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [GW:0]       rem_shift, rem_trial;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign rem_shift = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_trial = rem_shift - {1'b0, dvs_ff};
   assign status_o.div_last = (cnt_ff == CNT_W'(NUM_W - 1));

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd_i.load) begin
         rem_in = '0;
         quo_in = NUM_W'({integral_duty_ff, 1'b0}) << PRODUCT_SHIFT;
         cnt_in = '0;
      end else if (cmd_i.div_step) begin
         cnt_in = cnt_ff + 1'b1;
         if (!rem_trial[GW]) begin
            rem_in = rem_trial[GW-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[GW-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (cmd_i.load) begin
         dvs_ff <= gain_i_ff[GW-1] ? GW'(-gain_i_ff) : gain_i_ff;
      end
   end

   // signed limit, zero for a zero integral gain
   always_comb begin
      if (gain_i_ff == '0) begin
         lim_in = '0;
      end else if (gain_i_ff[GW-1]) begin
         lim_in = -$signed({1'b0, quo_ff});
      end else begin
         lim_in = $signed({1'b0, quo_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.lim_load) begin
         lim_ff <= lim_in;
      end
   end

   // shared multiplier, registered product
   logic signed [GW-1:0]              mul_a;
   logic signed [SW-1:0]              mul_b;
   logic signed [pci_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [EW:0]                err_diff;

   assign err_diff = (EW+1)'(error_now_ff) - (EW+1)'(error_before_ff);

   always_comb begin
      case (cmd_i.mul_sel)
         pci_pkg::MUL_SEL_P: begin
            mul_a = gain_p_ff;
            mul_b = SW'(error_now_ff);
         end
         pci_pkg::MUL_SEL_I: begin
            mul_a = gain_i_ff;
            mul_b = sum_ff;
         end
         pci_pkg::MUL_SEL_D: begin
            mul_a = gain_d_ff;
            mul_b = SW'(err_diff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // accumulator
   logic signed [TW-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (cmd_i.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd_i.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd_i.acc_add) begin
         acc_ff <= acc_ff + TW'(prod_ff);
      end
   end

   // scale and clamp to 0..full_duty
   logic [TW-1:0]                 acc_q;
   logic [pci_pkg::DRIVE_W-1:0]   drive_in, drive_ff;

   assign acc_q = acc_ff >>> PRODUCT_SHIFT;

   always_comb begin
      if (acc_ff <= 0) begin
         drive_in = '0;
      end else if (acc_q >= TW'(full_duty_ff)) begin
         drive_in = full_duty_ff;
      end else begin
         drive_in = acc_q[pci_pkg::DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.out_load) begin
         drive_ff <= drive_in;
      end
   end

   assign drive = drive_ff;

endmodule

@@ verif/pid_controller_integral_clamp_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_integral_clamp_tb
// Self-checking bench for the PID controller with integral clamp. A directed
// table exercises the field extremes, clear items, negative and zero integral
// gain, the error band and a zero full duty; then randomly configured phases
// of sample items follow. Each drive is checked against the table's value or a
// bit-accurate PID model kept in the bench, with random idling on both channels.
// ----------------------------------------------------------------------------
module pid_controller_integral_clamp_tb;

   localparam int PRODUCT_SHIFT = 12;
   localparam int SETTLE_CYCLES = 40;
   localparam int NO_CFG        = -1;
   localparam int MAX_SHOWN     = 10;
   localparam int RANDOM_PHASES = 18;
   localparam int QUIET_PHASES  = 2;

   localparam logic [pci_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   localparam longint SUM_MAX = 64'sd2147483647;
   localparam longint SUM_MIN = -64'sd2147483648;

   // one full register set, as written on the csr port
   typedef struct packed {
      logic [pci_pkg::CSR_DATA_W-1:0] setpoint, gain_p, gain_i, gain_d;
      logic [pci_pkg::CSR_DATA_W-1:0] error_band, integral_duty, full_duty;
   } pid_cfg_type;

   // directed item, with the register set to load before it
   typedef struct packed {
      int                           cfg;
      logic                         action;
      logic [pci_pkg::SAMPLE_W-1:0] sample;
      logic                         typed;
      logic [pci_pkg::DRIVE_W-1:0]  drive;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                           csr_wr_en;
   logic [pci_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pci_pkg::CSR_DATA_W-1:0] csr_wdata;

   pci_req_if req_bus();
   pci_rsp_if rsp_bus();

   pid_controller_integral_clamp #(
      .PRODUCT_SHIFT (PRODUCT_SHIFT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model copy of the registers
   logic signed [pci_pkg::SAMPLE_W-1:0] set_point;
   logic signed [pci_pkg::GAIN_W-1:0]   gain_p_reg, gain_i_reg, gain_d_reg;
   logic [pci_pkg::BAND_W-1:0]          band_reg;
   logic [pci_pkg::DUTY_W-1:0]          duty_i_reg, duty_full_reg;

   // model copy of the loop state
   logic signed [pci_pkg::ERR_W-1:0] pid_err_now, pid_err_old;
   logic signed [pci_pkg::SUM_W-1:0] pid_integral;

   logic [pci_pkg::DRIVE_W-1:0] pending_drives[$];
   int                          mismatch_count = 0;
   int                          rsp_hold       = 0;
   bit                          idle_on        = 1'b1;

   pid_cfg_type directed_cfgs [5] = '{
      '{17'd0, 17'd256, 17'd0, 17'd0, 17'h1FFFF, 17'd0, 17'd1000},
      '{17'd1600, 17'd128, 17'd64, 17'd512, 17'd800, 17'd500, 17'h0FFFF},
      '{17'h08000, 17'h08000, 17'h08000, 17'h07FFF, 17'd0, 17'h0FFFF, 17'd0},
      '{17'h07FFF, 17'h07FFF, 17'h07FFF, 17'h08000, 17'h1FFFF, 17'h0FFFF, 17'h0FFFF},
      '{17'd0, 17'd300, 17'h0FFFF, 17'd256, 17'd5000, 17'd1, 17'h0FFFF}
   };

   stim_row_type directed_rows [24] = '{
      // reset values: all gains zero
      '{NO_CFG, pci_pkg::ACTION_PROCESS, 16'd0,      1'b1, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_PROCESS, 16'h7FFF,   1'b1, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_PROCESS, 16'h8000,   1'b1, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_CLEAR,   16'h5A5A,   1'b0, 16'd0},
      // proportional only, gain of 1/16
      '{0,      pci_pkg::ACTION_PROCESS, -16'sd160,  1'b1, 16'd10},
      '{NO_CFG, pci_pkg::ACTION_PROCESS, 16'h8000,   1'b1, 16'd1000},
      '{NO_CFG, pci_pkg::ACTION_PROCESS, 16'h7FFF,   1'b1, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_PROCESS, -16'sd1,    1'b1, 16'd0},
      // full pid, error band crossed on the fourth sample
      '{1,      pci_pkg::ACTION_PROCESS, 16'sd1600,  1'b0, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_PROCESS, 16'sd1000,  1'b0, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_PROCESS, 16'sd1000,  1'b0, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_PROCESS, 16'sd0,     1'b0, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_CLEAR,   16'hFFFF,   1'b0, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_PROCESS, 16'sd1500,  1'b0, 16'd0},
      // zero full duty forces drive to zero
      '{2,      pci_pkg::ACTION_PROCESS, 16'h7FFF,   1'b1, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_PROCESS, 16'h8000,   1'b1, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_CLEAR,   16'h0000,   1'b0, 16'd0},
      // largest errors and gains
      '{3,      pci_pkg::ACTION_PROCESS, 16'h8000,   1'b0, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_PROCESS, 16'h7FFF,   1'b0, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_PROCESS, 16'h8000,   1'b0, 16'd0},
      // negative integral gain
      '{4,      pci_pkg::ACTION_PROCESS, 16'sd100,   1'b0, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_PROCESS, -16'sd100,  1'b0, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_CLEAR,   16'h1234,   1'b0, 16'd0},
      '{NO_CFG, pci_pkg::ACTION_PROCESS, 16'sd0,     1'b0, 16'd0}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint clip32(input longint v);
      if (v > SUM_MAX) return SUM_MAX;
      if (v < SUM_MIN) return SUM_MIN;
      return v;
   endfunction

   function automatic void reset_model();
      set_point     = '0;
      gain_p_reg    = '0;
      gain_i_reg    = '0;
      gain_d_reg    = '0;
      band_reg      = pci_pkg::ERROR_BAND_RST;
      duty_i_reg    = '0;
      duty_full_reg = pci_pkg::FULL_DUTY_RST;
      pid_err_now   = '0;
      pid_err_old   = '0;
      pid_integral  = '0;
   endfunction

   // one controller step: update errors and sum, work out the drive
   function automatic void step_pid(input logic act,
                                    input logic signed [pci_pkg::SAMPLE_W-1:0] smp,
                                    output logic has_drive,
                                    output logic [pci_pkg::DRIVE_W-1:0] drive);
      longint err, mag, lim, ki, sum, total, duty;
      has_drive = 1'b0;
      drive     = '0;
      if (act == pci_pkg::ACTION_CLEAR) begin
         pid_err_now  = '0;
         pid_err_old  = '0;
         pid_integral = '0;
         return;
      end
      pid_err_old = pid_err_now;
      err         = longint'(set_point) - longint'(smp);
      pid_err_now = pci_pkg::ERR_W'(err);
      sum = clip32(longint'(pid_integral) + err);
      // error outside the band drops the sum
      mag = (err < 0) ? -err : err;
      if (mag > longint'(band_reg)) sum = 0;
      // anti-windup limit, zero without integral gain
      ki  = longint'(gain_i_reg);
      lim = (ki != 0) ? ((longint'(duty_i_reg) * 2) <<< PRODUCT_SHIFT) / ki : 0;
      if (sum > lim) sum = lim;
      else if (sum < -lim) sum = -lim;
      sum = clip32(sum);
      pid_integral = pci_pkg::SUM_W'(sum);
      total = longint'(gain_p_reg) * err + ki * sum
            + longint'(gain_d_reg) * (err - longint'(pid_err_old));
      if (total <= 0) begin
         duty = 0;
      end else begin
         duty = total >>> PRODUCT_SHIFT;
         if (duty >= longint'(duty_full_reg)) duty = longint'(duty_full_reg);
      end
      has_drive = 1'b1;
      drive     = pci_pkg::DRIVE_W'(duty);
   endfunction

   function automatic void report_fault(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN) $display("%s", msg);
   endfunction

   function automatic logic [pci_pkg::GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return pci_pkg::GAIN_W'($urandom);
         1:       return '0;
         2:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
         default: return pci_pkg::GAIN_W'($urandom_range(0, 1200)) - 16'd600;
      endcase
   endfunction

   function automatic logic [pci_pkg::DUTY_W-1:0] pick_duty();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 16'hFFFF;
         2:       return pci_pkg::DUTY_W'($urandom);
         default: return pci_pkg::DUTY_W'($urandom_range(1, 2000));
      endcase
   endfunction

   // register write, caller sits on a rising edge
   task automatic write_csr(input logic [pci_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pci_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         pci_pkg::CSR_SETPOINT:      set_point     = data[pci_pkg::SAMPLE_W-1:0];
         pci_pkg::CSR_GAIN_P:        gain_p_reg    = data[pci_pkg::GAIN_W-1:0];
         pci_pkg::CSR_GAIN_I:        gain_i_reg    = data[pci_pkg::GAIN_W-1:0];
         pci_pkg::CSR_GAIN_D:        gain_d_reg    = data[pci_pkg::GAIN_W-1:0];
         pci_pkg::CSR_ERROR_BAND:    band_reg      = data[pci_pkg::BAND_W-1:0];
         pci_pkg::CSR_INTEGRAL_DUTY: duty_i_reg    = data[pci_pkg::DUTY_W-1:0];
         pci_pkg::CSR_FULL_DUTY:     duty_full_reg = data[pci_pkg::DUTY_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input pid_cfg_type c);
      write_csr(pci_pkg::CSR_SETPOINT, c.setpoint);
      write_csr(pci_pkg::CSR_GAIN_P, c.gain_p);
      write_csr(pci_pkg::CSR_GAIN_I, c.gain_i);
      write_csr(pci_pkg::CSR_GAIN_D, c.gain_d);
      write_csr(pci_pkg::CSR_ERROR_BAND, c.error_band);
      write_csr(pci_pkg::CSR_INTEGRAL_DUTY, c.integral_duty);
      write_csr(pci_pkg::CSR_FULL_DUTY, c.full_duty);
      // unmapped index must leave every register alone
      write_csr(CSR_UNUSED, pci_pkg::CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   // stop sending and wait for every pending drive
   task automatic drain_results(input int extra);
      req_bus.valid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // send one item, caller sits on a rising edge
   task automatic push_item(input logic act, input logic [pci_pkg::SAMPLE_W-1:0] smp,
                            input logic typed,
                            input logic [pci_pkg::DRIVE_W-1:0] typed_drive);
      logic                        has_drive;
      logic [pci_pkg::DRIVE_W-1:0] drv;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.action         <= act;
      req_bus.current_sample <= smp;
      do @(posedge clock); while (!req_bus.ready);
      step_pid(act, smp, has_drive, drv);
      if (has_drive) pending_drives.push_back(typed ? typed_drive : drv);
   endtask

   // receiver stalls in short bursts
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold      <= rsp_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_hold      <= $urandom_range(0, 2);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // drive checker
   always @(posedge clock) begin
      logic [pci_pkg::DRIVE_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_drives.size() == 0) begin
            report_fault($sformatf("unexpected drive %0d at %0t", rsp_bus.drive, $realtime));
         end else begin
            want = pending_drives.pop_front();
            if (rsp_bus.drive !== want)
               report_fault($sformatf("drive mismatch at %0t: expected %0d, got %0d",
                                      $realtime, want, rsp_bus.drive));
         end
      end
   end

   // stimulus
   initial begin
      int                           n_items;
      int                           pause_at;
      pid_cfg_type                  cfg;
      logic                         act;
      logic [pci_pkg::SAMPLE_W-1:0] smp;

      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.action         = pci_pkg::ACTION_PROCESS;
      req_bus.current_sample = '0;
      rsp_bus.ready          = 1'b0;
      csr_wr_en              = 1'b0;
      csr_index              = pci_pkg::CSR_SETPOINT;
      csr_wdata              = '0;
      reset_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg != NO_CFG) begin
            drain_results(SETTLE_CYCLES);
            apply_config(directed_cfgs[directed_rows[i].cfg]);
         end
         push_item(directed_rows[i].action, directed_rows[i].sample,
                   directed_rows[i].typed, directed_rows[i].drive);
      end

      // random phases, each with its own register set
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain_results(SETTLE_CYCLES);
         cfg.setpoint = {1'($urandom), ($urandom_range(0, 3) == 0)
                         ? pci_pkg::SAMPLE_W'($urandom)
                         : pci_pkg::SAMPLE_W'($urandom_range(0, 4000)) - 16'd2000};
         cfg.gain_p = {1'($urandom), pick_gain()};
         cfg.gain_i = {1'($urandom), pick_gain()};
         cfg.gain_d = {1'($urandom), pick_gain()};
         case ($urandom_range(0, 4))
            0:       cfg.error_band = '0;
            1:       cfg.error_band = 17'h1FFFF;
            2:       cfg.error_band = pci_pkg::BAND_W'($urandom);
            default: cfg.error_band = pci_pkg::BAND_W'($urandom_range(0, 1000));
         endcase
         cfg.integral_duty = {1'($urandom), pick_duty()};
         cfg.full_duty     = {1'($urandom), pick_duty()};
         apply_config(cfg);
         idle_on  = (ph < RANDOM_PHASES - QUIET_PHASES);
         n_items  = $urandom_range(70, 110);
         pause_at = $urandom_range(10, n_items - 10);
         for (int k = 0; k < n_items; k++) begin
            // hold off until the block has returned everything
            if (k == pause_at) drain_results(1);
            act = ($urandom_range(0, 11) == 0) ? pci_pkg::ACTION_CLEAR
                                                : pci_pkg::ACTION_PROCESS;
            case ($urandom_range(0, 5))
               0:       smp = pci_pkg::SAMPLE_W'($urandom);
               1:       smp = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
               default: smp = set_point + pci_pkg::SAMPLE_W'($urandom_range(0, 400))
                              - 16'd200;
            endcase
            push_item(act, smp, 1'b0, '0);
         end
      end

      drain_results(SETTLE_CYCLES);
      if (pending_drives.size() != 0)
         report_fault($sformatf("%0d drives never arrived", pending_drives.size()));
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // run limit
   initial begin
      #3ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
